FILE: src/pfa_pkg.sv
// Shared types and codes for the page frame allocator.
package pfa_pkg;

    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK         = 3'd0,
        STATUS_RANGE_FULL = 3'd1,
        STATUS_NOT_ALLOC  = 3'd2,
        STATUS_DOUBLE     = 3'd3,
        STATUS_STACK_FULL = 3'd4
    } status_t;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RANGE_START = 2'd0,
        REG_RANGE_END   = 2'd1,
        REG_SPARE_2     = 2'd2,
        REG_SPARE_3     = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_POP,
        S_SCAN,
        S_PUSH,
        S_OUT
    } seq_state_t;

    typedef struct packed {
        logic eq;
        logic ge;
    } cmp_res_t;

endpackage

FILE: src/page_frame_allocator_unit.sv
// Page frame allocator top level: configuration registers, sequencer and recycle stack.
//
//  channel | direction | signals
//  s_      | in        | s_valid, s_ready, s_cmd, s_frame_in
//  m_      | out       | m_valid, m_ready, m_frame_out, m_status
//  cfg_    | in        | cfg_valid, cfg_ready, cfg_index, cfg_data
//
// A bump allocate or a refused request goes from the check state to the result register;
// a pop reads the stack top first; a free scans one stack entry per cycle, then pushes.
// s_ready returns in the cycle after the output register loads: one request at a time.
// Reset clears the count and bump pointer; stack contents stay undefined.
// One result may wait on m_ready while the next request runs; that request then
// holds with s_ready low until the output register drains.
module page_frame_allocator_unit #(
    parameter int RECYCLE_DEPTH = 256,
    parameter int FRAME_BITS    = 44
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_cmd,
    input  logic [FRAME_BITS-1:0]         s_frame_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [FRAME_BITS-1:0]         m_frame_out,
    output logic [pfa_pkg::STATUS_W-1:0]  m_status,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pfa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [FRAME_BITS-1:0]         cfg_data
);
    import pfa_pkg::*;

    localparam int IDX_W = (RECYCLE_DEPTH > 1) ? $clog2(RECYCLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(RECYCLE_DEPTH + 1);

    logic [FRAME_BITS-1:0] range_start_reg, range_start_next;
    logic [FRAME_BITS-1:0] range_end_reg, range_end_next;
    logic                  start_we;

    logic                  ram_we, ram_re;
    logic [IDX_W-1:0]      ram_waddr, ram_raddr;
    logic [FRAME_BITS-1:0] ram_wdata, ram_rdata;

    assign cfg_ready = 1'b1;

    always_comb begin
        range_start_next = range_start_reg;
        range_end_next   = range_end_reg;
        start_we         = 1'b0;
        if (cfg_valid) begin
            unique case (reg_idx_t'(cfg_index))
                REG_RANGE_START: begin
                    range_start_next = cfg_data;
                    start_we         = 1'b1;
                end
                REG_RANGE_END: begin
                    range_end_next = cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_start_reg <= '0;
            range_end_reg   <= '0;
        end else begin
            range_start_reg <= range_start_next;
            range_end_reg   <= range_end_next;
        end
    end

    pfa_seq #(
        .FRAME_BITS    (FRAME_BITS),
        .RECYCLE_DEPTH (RECYCLE_DEPTH),
        .IDX_W         (IDX_W),
        .CNT_W         (CNT_W)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_frame_in  (s_frame_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_frame_out (m_frame_out),
        .m_status    (m_status),
        .start_we    (start_we),
        .range_start (range_start_next),
        .range_end   (range_end_reg),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata)
    );

    pfa_stack_ram #(
        .DEPTH (RECYCLE_DEPTH),
        .WIDTH (FRAME_BITS),
        .AW    (IDX_W)
    ) u_stack (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

FILE: src/pfa_cmp.sv
// Shared frame comparator: equality and unsigned greater-or-equal.
module pfa_cmp #(
    parameter int FRAME_BITS = 44
) (
    input  logic [FRAME_BITS-1:0] a,
    input  logic [FRAME_BITS-1:0] b,
    output pfa_pkg::cmp_res_t     res
);
    import pfa_pkg::*;

    always_comb begin
        res.eq = (a == b);
        res.ge = (a >= b);
    end

endmodule

FILE: src/pfa_stack_ram.sv
// Recycle stack storage with registered read.
module pfa_stack_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 44,
    parameter int AW    = 8
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: src/pfa_seq.sv
// Request sequencer: bump pointer, stack count, duplicate scan and result register.
module pfa_seq #(
    parameter int FRAME_BITS    = 44,
    parameter int RECYCLE_DEPTH = 256,
    parameter int IDX_W         = 8,
    parameter int CNT_W         = 9
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_cmd,
    input  logic [FRAME_BITS-1:0]    s_frame_in,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [FRAME_BITS-1:0]    m_frame_out,
    output logic [pfa_pkg::STATUS_W-1:0] m_status,
    input  logic                     start_we,
    input  logic [FRAME_BITS-1:0]    range_start,
    input  logic [FRAME_BITS-1:0]    range_end,
    output logic                     ram_we,
    output logic [IDX_W-1:0]         ram_waddr,
    output logic [FRAME_BITS-1:0]    ram_wdata,
    output logic                     ram_re,
    output logic [IDX_W-1:0]         ram_raddr,
    input  logic [FRAME_BITS-1:0]    ram_rdata
);
    import pfa_pkg::*;

    seq_state_t            state_reg, state_next;
    logic                  cmd_reg, cmd_next;
    logic [FRAME_BITS-1:0] frame_reg, frame_next;
    logic [FRAME_BITS-1:0] next_unused_reg, next_unused_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [IDX_W-1:0]      scan_reg, scan_next;
    logic [FRAME_BITS-1:0] res_frame_reg, res_frame_next;
    status_t               res_status_reg, res_status_next;
    logic [FRAME_BITS-1:0] out_frame_reg, out_frame_next;
    status_t               out_status_reg, out_status_next;
    logic                  out_valid_reg, out_valid_next;

    logic [FRAME_BITS-1:0] cmp_a, cmp_b;
    cmp_res_t              cmp_res;

    pfa_cmp #(.FRAME_BITS(FRAME_BITS)) u_cmp (
        .a   (cmp_a),
        .b   (cmp_b),
        .res (cmp_res)
    );

    assign s_ready     = (state_reg == S_IDLE);
    assign m_valid     = out_valid_reg;
    assign m_frame_out = out_frame_reg;
    assign m_status    = out_status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            next_unused_reg <= '0;
            count_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg       <= state_next;
            next_unused_reg <= next_unused_next;
            count_reg       <= count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        frame_reg      <= frame_next;
        scan_reg       <= scan_next;
        res_frame_reg  <= res_frame_next;
        res_status_reg <= res_status_next;
        out_frame_reg  <= out_frame_next;
        out_status_reg <= out_status_next;
    end

    always_comb begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        frame_next       = frame_reg;
        next_unused_next = next_unused_reg;
        count_next       = count_reg;
        scan_next        = scan_reg;
        res_frame_next   = res_frame_reg;
        res_status_next  = res_status_reg;
        out_frame_next   = out_frame_reg;
        out_status_next  = out_status_reg;
        out_valid_next   = out_valid_reg;
        ram_we           = 1'b0;
        ram_waddr        = count_reg[IDX_W-1:0];
        ram_wdata        = frame_reg;
        ram_re           = 1'b0;
        ram_raddr        = scan_reg;
        cmp_a            = frame_reg;
        cmp_b            = next_unused_reg;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd_next   = s_cmd;
                    frame_next = s_frame_in;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                res_frame_next = '0;
                if (cmd_reg == CMD_ALLOC) begin
                    cmp_a = next_unused_reg;
                    cmp_b = range_end;
                    if (count_reg != '0) begin
                        ram_re     = 1'b1;
                        ram_raddr  = IDX_W'(count_reg - CNT_W'(1));
                        state_next = S_POP;
                    end else if (cmp_res.ge) begin
                        res_status_next = STATUS_RANGE_FULL;
                        state_next      = S_OUT;
                    end else begin
                        res_frame_next   = next_unused_reg;
                        res_status_next  = STATUS_OK;
                        next_unused_next = next_unused_reg + FRAME_BITS'(1);
                        state_next       = S_OUT;
                    end
                end else begin
                    if (cmp_res.ge) begin
                        res_status_next = STATUS_NOT_ALLOC;
                        state_next      = S_OUT;
                    end else if (count_reg == '0) begin
                        state_next = S_PUSH;
                    end else begin
                        ram_re     = 1'b1;
                        ram_raddr  = '0;
                        scan_next  = '0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_POP: begin
                res_frame_next  = ram_rdata;
                res_status_next = STATUS_OK;
                count_next      = count_reg - CNT_W'(1);
                state_next      = S_OUT;
            end
            S_SCAN: begin
                cmp_a = ram_rdata;
                cmp_b = frame_reg;
                if (cmp_res.eq) begin
                    res_status_next = STATUS_DOUBLE;
                    state_next      = S_OUT;
                end else if (CNT_W'(scan_reg) + CNT_W'(1) == count_reg) begin
                    state_next = S_PUSH;
                end else begin
                    ram_re     = 1'b1;
                    ram_raddr  = scan_reg + IDX_W'(1);
                    scan_next  = scan_reg + IDX_W'(1);
                end
            end
            S_PUSH: begin
                if (count_reg == CNT_W'(RECYCLE_DEPTH)) begin
                    res_status_next = STATUS_STACK_FULL;
                end else begin
                    ram_we          = 1'b1;
                    count_next      = count_reg + CNT_W'(1);
                    res_status_next = STATUS_OK;
                end
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!out_valid_reg || m_ready) begin
                    out_frame_next  = res_frame_reg;
                    out_status_next = res_status_reg;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (start_we) begin
            next_unused_next = range_start;
            count_next       = '0;
        end
    end

endmodule
